/* rtl/aco_pkg.sv */
// Package for the binary-choice ant colony optimizer.
// Holds the sequencer states, codes, constants and the LFSR step.
// No dependencies.
`default_nettype none
package aco_pkg;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam logic [2:0] CFG_GAIN  = 3'd0;
    localparam logic [2:0] CFG_EVAP  = 3'd1;
    localparam logic [2:0] CFG_THR   = 3'd2;
    localparam logic [2:0] CFG_ITER  = 3'd3;
    localparam logic [2:0] CFG_STEPS = 3'd4;
    localparam logic [2:0] CFG_SEED  = 3'd5;

    localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;
    localparam logic [31:0] PH_MAX    = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_W_RD,
        ST_W_DEC,
        ST_E_RD,
        ST_E_WR,
        ST_D_RDC,
        ST_D_LDP,
        ST_C_RD,
        ST_C_ACC,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_P_RD,
        ST_P_WR,
        ST_O_RD,
        ST_O_LD,
        ST_O_HOLD
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [31:0] lfsr_step(input logic [31:0] x);
        logic [31:0] r;
        r = {1'b0, x[31:1]};
        if (x[0])
        begin
            r = r ^ LFSR_TAPS;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/binary_choice_ant_colony_optimizer.sv */
// Top level of the binary-choice ant colony optimizer: sequencer, cost,
// pheromone and path memories. Depends on aco_pkg and aco_div.
//
// Channel    Direction  Handshake                   Contents
// s_axis     in         s_axis_tvalid/tready        load cost pair or start a run
// m_axis     out        m_axis_tvalid/tready        pheromone pair of one step
// cfg        in         cfg_we                      register write, no wait
//
// A load item leaves the block idle and ready for the next item. A start item
// runs I rounds of A ants over S steps, its pace set by the single-port
// pheromone memory (a read and then a write per read-modify-write) and the
// serial divider, and then sends one result per step.
// Reset clears control state only; a load marks all pheromone entries as zero.
// No item is accepted until the last result of a run has been taken.
`default_nettype none
module binary_choice_ant_colony_optimizer
    import aco_pkg::*;
#(
    parameter int MAX_STEPS = 64,
    parameter int MAX_ANTS  = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // left_cost, right_cost, ant_count
    input  wire logic        s_axis_tuser,   // operation
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,   // step_index, left_pheromone, right_pheromone
    output logic             m_axis_tlast,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [31:0] cfg_wdata
);

    localparam int SW  = $clog2(MAX_STEPS);
    localparam int AW  = (MAX_ANTS > 1) ? $clog2(MAX_ANTS) : 1;
    localparam int ACW = $clog2(MAX_ANTS + 1);
    localparam int TW  = 16 + SW;

    state_t state_reg, state_next;

    logic [15:0] gain_reg, evap_reg, thr_reg, iter_lim_reg;
    logic [6:0]  steps_reg;
    logic [31:0] seed_reg;

    logic [SW:0]    load_pos_reg;
    logic [SW-1:0]  step_reg, last_reg;
    logic [AW-1:0]  ant_reg;
    logic [ACW-1:0] ants_reg;
    logic [15:0]    iter_left_reg;
    logic [31:0]    lfsr_reg;
    logic [MAX_STEPS-1:0] path_reg;
    logic [MAX_STEPS-1:0] ph_valid_reg;
    logic [TW-1:0]  total_reg;
    logic [31:0]    dep_reg;
    logic           out_valid_reg;
    logic [5:0]     out_step_reg;
    logic [31:0]    out_left_reg, out_right_reg;
    logic           out_last_reg;

    logic [31:0] cost_mem [MAX_STEPS];
    logic [63:0] ph_mem   [MAX_STEPS];
    logic [MAX_STEPS-1:0] ch_mem [MAX_ANTS];
    logic [31:0] cost_q;
    logic [63:0] ph_q;
    logic        vld_q;
    logic [MAX_STEPS-1:0] ch_q;

    logic        in_acc, is_start;
    logic [15:0] in_left, in_right;
    logic [4:0]  in_ants;
    logic [31:0] ant_clamp, steps32, last32;
    logic        step_last, ant_last, iter_last;
    logic [31:0] ph_l, ph_r;
    logic [31:0] r1, r2, lfsr_nx;
    logic        explore, pick;
    logic [MAX_STEPS-1:0] path_new;
    logic [47:0] ev_l, ev_r;
    logic        side;
    logic [32:0] dep_sum;
    logic [31:0] dep_res;
    logic        ph_we, ch_we, cost_we, div_start;
    logic [63:0] ph_wdata;
    logic [31:0] div_quot;
    div_stat_t   div_stat;
    state_t      it_end_state;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign is_start = (s_axis_tuser == OP_START);
    assign in_left  = s_axis_tdata[15:0];
    assign in_right = s_axis_tdata[31:16];
    assign in_ants  = s_axis_tdata[36:32];

    assign ant_clamp = ({27'b0, in_ants} > 32'(MAX_ANTS)) ? 32'(MAX_ANTS) : {27'b0, in_ants};
    assign steps32   = {25'b0, steps_reg};
    assign last32    = (steps32 == 32'd0) ? 32'd0 :
                       (steps32 > 32'(MAX_STEPS)) ? 32'(MAX_STEPS - 1) : steps32 - 32'd1;

    assign step_last = (step_reg == last_reg);
    assign ant_last  = ((ACW'(ant_reg) + ACW'(1)) == ants_reg);
    assign iter_last = (iter_left_reg == 16'd1);

    assign ph_l = vld_q ? ph_q[31:0]  : 32'd0;
    assign ph_r = vld_q ? ph_q[63:32] : 32'd0;

    assign r1      = lfsr_step(lfsr_reg);
    assign r2      = lfsr_step(r1);
    assign explore = (r1[31:16] < thr_reg) || (ph_l == ph_r);
    assign pick    = explore ? r2[31] : !(ph_l > ph_r);
    assign lfsr_nx = explore ? r2 : r1;

    always_comb
    begin
        path_new           = path_reg;
        path_new[step_reg] = pick;
    end

    assign ev_l = {16'b0, ph_l} * {32'b0, evap_reg};
    assign ev_r = {16'b0, ph_r} * {32'b0, evap_reg};

    assign side    = path_reg[step_reg];
    assign dep_sum = {1'b0, (side ? ph_r : ph_l)} + {1'b0, dep_reg};
    assign dep_res = dep_sum[32] ? PH_MAX : dep_sum[31:0];

    aco_div #(
        .DW (TW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({gain_reg, 16'b0}),
        .divisor  (total_reg),
        .quot     (div_quot),
        .stat     (div_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg     <= 16'd100;
            evap_reg     <= 16'd58982;
            thr_reg      <= 16'd6554;
            iter_lim_reg <= 16'd100;
            steps_reg    <= 7'd64;
            seed_reg     <= 32'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_GAIN:  gain_reg     <= cfg_wdata[15:0];
                CFG_EVAP:  evap_reg     <= cfg_wdata[15:0];
                CFG_THR:   thr_reg      <= cfg_wdata[15:0];
                CFG_ITER:  iter_lim_reg <= cfg_wdata[15:0];
                CFG_STEPS: steps_reg    <= cfg_wdata[6:0];
                CFG_SEED:  seed_reg     <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        ph_we        = 1'b0;
        ph_wdata     = {ph_r, ph_l};
        ch_we        = 1'b0;
        cost_we      = 1'b0;
        div_start    = 1'b0;
        it_end_state = iter_last ? ST_O_RD : ((ants_reg == '0) ? ST_E_RD : ST_W_RD);
        s_axis_tready = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (is_start)
                    begin
                        state_next = (ant_clamp == 32'd0) ? ST_E_RD : ST_W_RD;
                    end
                    else
                    begin
                        cost_we = (load_pos_reg < (SW+1)'(MAX_STEPS));
                    end
                end
            end
            ST_W_RD:
            begin
                state_next = ST_W_DEC;
            end
            ST_W_DEC:
            begin
                state_next = ST_W_RD;
                if (step_last)
                begin
                    ch_we = 1'b1;
                    if (ant_last)
                    begin
                        state_next = ST_E_RD;
                    end
                end
            end
            ST_E_RD:
            begin
                state_next = ST_E_WR;
            end
            ST_E_WR:
            begin
                ph_we      = 1'b1;
                ph_wdata   = {ev_r[47:16], ev_l[47:16]};
                state_next = ST_E_RD;
                if (step_last)
                begin
                    state_next = (ants_reg == '0) ? it_end_state : ST_D_RDC;
                end
            end
            ST_D_RDC:
            begin
                state_next = ST_D_LDP;
            end
            ST_D_LDP:
            begin
                state_next = ST_C_RD;
            end
            ST_C_RD:
            begin
                state_next = ST_C_ACC;
            end
            ST_C_ACC:
            begin
                state_next = step_last ? ST_DIV_GO : ST_C_RD;
            end
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_P_RD;
                end
            end
            ST_P_RD:
            begin
                state_next = ST_P_WR;
            end
            ST_P_WR:
            begin
                ph_we      = 1'b1;
                ph_wdata   = side ? {dep_res, ph_l} : {ph_r, dep_res};
                state_next = ST_P_RD;
                if (step_last)
                begin
                    state_next = ant_last ? it_end_state : ST_D_RDC;
                end
            end
            ST_O_RD:
            begin
                state_next = ST_O_LD;
            end
            ST_O_LD:
            begin
                state_next = ST_O_HOLD;
            end
            ST_O_HOLD:
            begin
                if (m_axis_tready)
                begin
                    state_next = step_last ? ST_IDLE : ST_O_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_pos_reg  <= '0;
            step_reg      <= '0;
            last_reg      <= '0;
            ant_reg       <= '0;
            ants_reg      <= '0;
            iter_left_reg <= 16'd1;
            lfsr_reg      <= 32'd1;
            ph_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (is_start)
                        begin
                            step_reg      <= '0;
                            ant_reg       <= '0;
                            ants_reg      <= ACW'(ant_clamp);
                            last_reg      <= SW'(last32);
                            iter_left_reg <= (iter_lim_reg == 16'd0) ? 16'd1 : iter_lim_reg;
                            lfsr_reg      <= (seed_reg == 32'd0) ? 32'd1 : seed_reg;
                            load_pos_reg  <= '0;
                        end
                        else
                        begin
                            if (cost_we)
                            begin
                                load_pos_reg <= load_pos_reg + (SW+1)'(1);
                            end
                            ph_valid_reg <= '0;
                        end
                    end
                end
                ST_W_DEC:
                begin
                    lfsr_reg <= lfsr_nx;
                    if (step_last)
                    begin
                        step_reg <= '0;
                        ant_reg  <= ant_last ? '0 : ant_reg + AW'(1);
                    end
                    else
                    begin
                        step_reg <= step_reg + SW'(1);
                    end
                end
                ST_E_WR:
                begin
                    ph_valid_reg[step_reg] <= 1'b1;
                    if (step_last)
                    begin
                        step_reg <= '0;
                        ant_reg  <= '0;
                        if (ants_reg == '0)
                        begin
                            iter_left_reg <= iter_left_reg - 16'd1;
                        end
                    end
                    else
                    begin
                        step_reg <= step_reg + SW'(1);
                    end
                end
                ST_D_LDP:
                begin
                    step_reg <= '0;
                end
                ST_C_ACC:
                begin
                    step_reg <= step_last ? '0 : step_reg + SW'(1);
                end
                ST_P_WR:
                begin
                    ph_valid_reg[step_reg] <= 1'b1;
                    if (step_last)
                    begin
                        step_reg <= '0;
                        if (ant_last)
                        begin
                            ant_reg       <= '0;
                            iter_left_reg <= iter_left_reg - 16'd1;
                        end
                        else
                        begin
                            ant_reg <= ant_reg + AW'(1);
                        end
                    end
                    else
                    begin
                        step_reg <= step_reg + SW'(1);
                    end
                end
                ST_O_LD:
                begin
                    out_valid_reg <= 1'b1;
                end
                ST_O_HOLD:
                begin
                    if (m_axis_tready)
                    begin
                        out_valid_reg <= 1'b0;
                        step_reg      <= step_reg + SW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_W_DEC:
            begin
                path_reg <= path_new;
            end
            ST_D_LDP:
            begin
                path_reg  <= ch_q;
                total_reg <= '0;
            end
            ST_C_ACC:
            begin
                total_reg <= total_reg + TW'(side ? cost_q[31:16] : cost_q[15:0]);
            end
            ST_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    dep_reg <= (total_reg == '0) ? PH_MAX : div_quot;
                end
            end
            ST_O_LD:
            begin
                out_step_reg  <= 6'(step_reg);
                out_left_reg  <= ph_l;
                out_right_reg <= ph_r;
                out_last_reg  <= step_last;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cost_we)
        begin
            cost_mem[load_pos_reg[SW-1:0]] <= {in_right, in_left};
        end
        cost_q <= cost_mem[step_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ph_we)
        begin
            ph_mem[step_reg] <= ph_wdata;
        end
        ph_q  <= ph_mem[step_reg];
        vld_q <= ph_valid_reg[step_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ch_we)
        begin
            ch_mem[ant_reg] <= path_new;
        end
        ch_q <= ch_mem[ant_reg];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b0, out_right_reg, out_left_reg, out_step_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule
`default_nettype wire

/* rtl/aco_div.sv */
// Restoring divider, one quotient bit per cycle, 32-bit dividend.
// Depends on aco_pkg for the status struct.
`default_nettype none
module aco_div
    import aco_pkg::*;
#(
    parameter int DW = 22
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [31:0]   dividend,
    input  wire logic [DW-1:0] divisor,
    output logic [31:0]        quot,
    output div_stat_t          stat
);

    logic [4:0]    cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW-1:0] rem_reg;
    logic [31:0]   quo_reg;
    logic [DW-1:0] dvs_reg;

    logic [DW:0]   shifted;
    logic [DW+1:0] diff;

    assign shifted = {rem_reg, quo_reg[31]};
    assign diff    = {1'b0, shifted} - {2'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DW+1])
            begin
                rem_reg <= diff[DW-1:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DW-1:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    assign quot      = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
`default_nettype wire

/* rtl/aco_checker.sv */
// Port-level checks for the binary-choice ant colony optimizer.
// Bound to binary_choice_ant_colony_optimizer; no package dependency.
`default_nettype none
module aco_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic        m_axis_tlast,
    input wire logic [71:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result item changed while stalled");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input taken while a result is pending");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("block not idle after final result");

    a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tuser) |=> s_axis_tready)
        else $error("load item did not complete in one cycle");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> !s_axis_tready)
        else $error("start item did not make the block busy");

endmodule

bind binary_choice_ant_colony_optimizer aco_checker u_aco_checker (.*);
`default_nettype wire
